// File: sv/ccds_pkg.sv
`timescale 1ns / 1ps

package ccds_pkg;

  // Field widths.
  localparam int INDEX_W = 10;
  localparam int AMP_W   = 16;
  localparam int DUR_W   = 16;
  localparam int SCALE_W = 15;
  localparam int CLS_W   = 3;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 15;

  // Q1.14 scale format.
  localparam int FRAC_BITS = 14;
  localparam int PROD_W    = DUR_W + SCALE_W;
  localparam logic [SCALE_W-1:0] ONE_Q14 = SCALE_W'(16384);

  // Fixed rule constants.
  localparam logic [SCALE_W-1:0] AFFRICATE_SCALE = SCALE_W'(16384);
  localparam logic [AMP_W-1:0]   FRIC_THRESHOLD  = AMP_W'(3277);
  localparam logic [DUR_W-1:0]   MIN_DURATION    = DUR_W'(32);

  // Bit positions in a phoneme class word.
  localparam int CLS_CONS = 0;
  localparam int CLS_STOP = 1;
  localparam int CLS_FRIC = 2;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE            = 4'd0,
    REG_TRIPLE_MIDDLE     = 4'd1,
    REG_FRIC_BEFORE_STOP  = 4'd2,
    REG_STOP_BEFORE_FRIC  = 4'd3,
    REG_FRIC_BEFORE_FRIC  = 4'd4,
    REG_STOP_BEFORE_STOP  = 4'd5,
    REG_WORD_MEDIAL       = 4'd6,
    REG_WORD_FINAL_OBSTR  = 4'd7
  } cfg_reg_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_PLAN,
    S_SCALE,
    S_EMIT
  } state_t;

  // Input beat.
  typedef struct packed {
    logic [INDEX_W-1:0] token_index;
    logic               is_silence;
    logic               is_vowel;
    logic               is_stop;
    logic               is_affricate;
    logic [AMP_W-1:0]   frication_amplitude;
    logic               word_start;
    logic [DUR_W-1:0]   duration;
    logic [DUR_W-1:0]   fade;
    logic               last_token;
  } tok_in_t;

  // Result beat.
  typedef struct packed {
    logic [INDEX_W-1:0] out_index;
    logic [DUR_W-1:0]   out_duration;
    logic [DUR_W-1:0]   out_fade;
    logic               end_of_run;
  } res_t;

  // A token as the datapath keeps it.
  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic [CLS_W-1:0]   cls;
    logic               affricate;
    logic               wstart;
    logic [DUR_W-1:0]   dur;
    logic [DUR_W-1:0]   fade;
  } token_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load_cur;
    logic absorb;
    logic shift;
    logic close;
    logic load_scale;
    logic mul_dur;
    logic nxt_none;
    logic emit;
    logic end_run;
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic cur_silence;
    logic cur_last;
    logic held_valid;
    logic out_free;
  } stat_t;

endpackage

// File: sv/ccds_tok_if.sv
`timescale 1ns / 1ps

interface ccds_tok_if;
  logic              valid;
  logic              ready;
  ccds_pkg::tok_in_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// File: sv/ccds_res_if.sv
`timescale 1ns / 1ps

interface ccds_res_if;
  logic           valid;
  logic           ready;
  ccds_pkg::res_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// File: sv/ccds_cfg_if.sv
`timescale 1ns / 1ps

interface ccds_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [ccds_pkg::CFG_IDX_W-1:0]      index;
  logic [ccds_pkg::CFG_DATA_W-1:0]     data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

// File: sv/ccds_ctrl.sv
`timescale 1ns / 1ps

module ccds_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             tok_valid,
  output logic             tok_ready,
  input  ccds_pkg::stat_t  stat,
  output ccds_pkg::cmd_t   cmd
);

  ccds_pkg::state_t state, state_next;
  logic             phase_b, phase_b_next;

  // State and release-phase registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ccds_pkg::S_IDLE;
      phase_b <= 1'b0;
    end else begin
      state   <= state_next;
      phase_b <= phase_b_next;
    end
  end

  // Next state and commands. Phase A releases the held token against the new
  // one; phase B releases it as word-final at the end of a sequence.
  always_comb begin
    state_next   = state;
    phase_b_next = phase_b;
    cmd          = '0;
    tok_ready    = 1'b0;
    case (state)
      ccds_pkg::S_IDLE: begin
        tok_ready = 1'b1;
        if (tok_valid) begin
          cmd.load_cur = 1'b1;
          state_next   = ccds_pkg::S_PLAN;
        end
      end
      ccds_pkg::S_PLAN: begin
        if (!stat.cur_silence && stat.held_valid) begin
          phase_b_next = 1'b0;
          state_next   = ccds_pkg::S_SCALE;
        end else begin
          if (!stat.cur_silence) begin
            cmd.absorb = 1'b1;
          end
          if (stat.cur_last) begin
            if (stat.held_valid || !stat.cur_silence) begin
              phase_b_next = 1'b1;
              state_next   = ccds_pkg::S_SCALE;
            end else begin
              cmd.close  = 1'b1;
              state_next = ccds_pkg::S_IDLE;
            end
          end else begin
            state_next = ccds_pkg::S_IDLE;
          end
        end
      end
      ccds_pkg::S_SCALE: begin
        cmd.load_scale = 1'b1;
        cmd.nxt_none   = phase_b;
        state_next     = ccds_pkg::S_EMIT;
      end
      ccds_pkg::S_EMIT: begin
        cmd.mul_dur  = 1'b1;
        cmd.nxt_none = phase_b;
        if (stat.out_free) begin
          cmd.emit    = 1'b1;
          cmd.end_run = phase_b || !stat.cur_last;
          if (phase_b) begin
            cmd.close  = 1'b1;
            state_next = ccds_pkg::S_IDLE;
          end else begin
            cmd.shift = 1'b1;
            if (stat.cur_last) begin
              phase_b_next = 1'b1;
              state_next   = ccds_pkg::S_SCALE;
            end else begin
              state_next = ccds_pkg::S_IDLE;
            end
          end
        end
      end
      default: begin
        state_next = ccds_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// File: sv/ccds_datapath.sv
`timescale 1ns / 1ps

module ccds_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  ccds_pkg::cmd_t                    cmd,
  output ccds_pkg::stat_t                   stat,
  input  ccds_pkg::tok_in_t                 tok_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ccds_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ccds_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                              res_valid,
  input  logic                              res_ready,
  output ccds_pkg::res_t                    res_data
);

  localparam int SW = ccds_pkg::SCALE_W;
  localparam int DW = ccds_pkg::DUR_W;
  localparam int FB = ccds_pkg::FRAC_BITS;
  localparam int PW = ccds_pkg::PROD_W;

  // Configuration registers.
  logic          enable;
  logic [SW-1:0] triple_middle_scale;
  logic [SW-1:0] fric_before_stop_scale;
  logic [SW-1:0] stop_before_fric_scale;
  logic [SW-1:0] fric_before_fric_scale;
  logic [SW-1:0] stop_before_stop_scale;
  logic [SW-1:0] word_medial_scale;
  logic [SW-1:0] word_final_obstruent_scale;

  // Token storage.
  ccds_pkg::token_t                cur;
  logic                            cur_silence;
  logic                            cur_last;
  ccds_pkg::token_t                held;
  logic                            held_valid;
  logic [ccds_pkg::CLS_W-1:0]      cls_before;
  logic [SW-1:0]                   scale_q;

  // Result register.
  logic            out_valid;
  ccds_pkg::res_t  out_data;

  ccds_pkg::token_t in_tok;
  logic             in_stop;

  logic          pc, nc, in_cluster, wfinal;
  logic          cs, cf, ns, nf, ps, pf;
  logic [SW-1:0] s_pre;
  logic [SW-1:0] s_fin;
  logic          adjust;
  logic [DW-1:0] mul_a;
  logic [SW-1:0] mul_b;
  logic [PW-1:0] prod;
  logic [DW-1:0] dur_scaled;
  logic [DW-1:0] dur_new;
  logic [DW-1:0] fade_new;

  assign cfg_ready = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      enable                     <= 1'b0;
      triple_middle_scale        <= ccds_pkg::ONE_Q14;
      fric_before_stop_scale     <= ccds_pkg::ONE_Q14;
      stop_before_fric_scale     <= ccds_pkg::ONE_Q14;
      fric_before_fric_scale     <= ccds_pkg::ONE_Q14;
      stop_before_stop_scale     <= ccds_pkg::ONE_Q14;
      word_medial_scale          <= ccds_pkg::ONE_Q14;
      word_final_obstruent_scale <= ccds_pkg::ONE_Q14;
    end else if (cfg_valid) begin
      case (cfg_index)
        ccds_pkg::REG_ENABLE:           enable                     <= cfg_data[0];
        ccds_pkg::REG_TRIPLE_MIDDLE:    triple_middle_scale        <= cfg_data;
        ccds_pkg::REG_FRIC_BEFORE_STOP: fric_before_stop_scale     <= cfg_data;
        ccds_pkg::REG_STOP_BEFORE_FRIC: stop_before_fric_scale     <= cfg_data;
        ccds_pkg::REG_FRIC_BEFORE_FRIC: fric_before_fric_scale     <= cfg_data;
        ccds_pkg::REG_STOP_BEFORE_STOP: stop_before_stop_scale     <= cfg_data;
        ccds_pkg::REG_WORD_MEDIAL:      word_medial_scale          <= cfg_data;
        ccds_pkg::REG_WORD_FINAL_OBSTR: word_final_obstruent_scale <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Classify the incoming beat.
  assign in_stop = tok_data.is_stop | tok_data.is_affricate;
  always_comb begin
    in_tok.index      = tok_data.token_index;
    in_tok.cls[ccds_pkg::CLS_CONS] = ~tok_data.is_vowel;
    in_tok.cls[ccds_pkg::CLS_STOP] = in_stop;
    in_tok.cls[ccds_pkg::CLS_FRIC] = ~in_stop &&
        (tok_data.frication_amplitude >= ccds_pkg::FRIC_THRESHOLD);
    in_tok.affricate  = tok_data.is_affricate;
    in_tok.wstart     = tok_data.word_start;
    in_tok.dur        = tok_data.duration;
    in_tok.fade       = tok_data.fade;
  end

  // Incoming token register.
  always_ff @(posedge clk) begin
    if (cmd.load_cur) begin
      cur         <= in_tok;
      cur_silence <= tok_data.is_silence;
      cur_last    <= tok_data.last_token;
    end
  end

  // Held token and the class of the token before it.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      cls_before <= '0;
    end else begin
      if (cmd.absorb || cmd.shift) begin
        held_valid <= 1'b1;
      end else if (cmd.close) begin
        held_valid <= 1'b0;
      end
      if (cmd.shift) begin
        cls_before <= held.cls;
      end else if (cmd.close) begin
        cls_before <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.absorb || cmd.shift) begin
      held <= cur;
    end
  end

  // Neighbor classes of the held token.
  always_comb begin
    pc         = cls_before[ccds_pkg::CLS_CONS];
    nc         = !cmd.nxt_none && cur.cls[ccds_pkg::CLS_CONS];
    in_cluster = pc || nc;
    wfinal     = cmd.nxt_none || cur.wstart;
    cs         = held.cls[ccds_pkg::CLS_STOP];
    cf         = held.cls[ccds_pkg::CLS_FRIC];
    ns         = cur.cls[ccds_pkg::CLS_STOP];
    nf         = cur.cls[ccds_pkg::CLS_FRIC];
    ps         = cls_before[ccds_pkg::CLS_STOP];
    pf         = cls_before[ccds_pkg::CLS_FRIC];
  end

  // Cluster rules, ahead of the affricate factor.
  always_comb begin
    s_pre = ccds_pkg::ONE_Q14;
    if (pc && nc) begin
      if (triple_middle_scale < s_pre) s_pre = triple_middle_scale;
    end else begin
      if (nc) begin
        if (cf && ns) begin
          if (fric_before_stop_scale < s_pre) s_pre = fric_before_stop_scale;
        end else if (cs && nf) begin
          if (stop_before_fric_scale < s_pre) s_pre = stop_before_fric_scale;
        end else if (cf && nf) begin
          if (fric_before_fric_scale < s_pre) s_pre = fric_before_fric_scale;
        end else if (cs && ns) begin
          if (stop_before_stop_scale < s_pre) s_pre = stop_before_stop_scale;
        end
      end
      if (pc) begin
        if (pf && cs) begin
          // A stop after a fricative keeps its length.
        end else if (ps && cf) begin
          if (stop_before_fric_scale < s_pre) s_pre = stop_before_fric_scale;
        end else if (pf && cf) begin
          if (fric_before_fric_scale < s_pre) s_pre = fric_before_fric_scale;
        end else if (ps && cs) begin
          if (stop_before_stop_scale < s_pre) s_pre = stop_before_stop_scale;
        end
      end
    end
  end

  // Shared multiplier: affricate factor first, then the duration.
  assign mul_a = cmd.mul_dur ? held.dur : DW'(s_pre);
  assign mul_b = cmd.mul_dur ? s_fin : ccds_pkg::AFFRICATE_SCALE;
  assign prod  = PW'(mul_a) * PW'(mul_b);

  always_ff @(posedge clk) begin
    if (cmd.load_scale) begin
      if (in_cluster && held.affricate) begin
        scale_q <= prod[FB+SW-1:FB];
      end else begin
        scale_q <= s_pre;
      end
    end
  end

  // Word-position rules after the affricate factor.
  always_comb begin
    s_fin = scale_q;
    if (!held.wstart && !wfinal && !in_cluster) begin
      if (word_medial_scale < s_fin) s_fin = word_medial_scale;
    end
    if (wfinal && (cs || cf)) begin
      if (word_final_obstruent_scale < s_fin) s_fin = word_final_obstruent_scale;
    end
  end

  // Scaled duration, floored, and the fade clamped to it.
  assign adjust     = enable && held.cls[ccds_pkg::CLS_CONS] && (s_fin < ccds_pkg::ONE_Q14);
  assign dur_scaled = prod[FB+DW-1:FB];
  always_comb begin
    dur_new  = held.dur;
    fade_new = held.fade;
    if (adjust) begin
      dur_new = (dur_scaled < ccds_pkg::MIN_DURATION) ? ccds_pkg::MIN_DURATION : dur_scaled;
      if (held.fade > dur_new) fade_new = dur_new;
    end
  end

  // Output register: a waiting beat does not block the next one from forming.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (res_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.out_index    <= held.index;
      out_data.out_duration <= dur_new;
      out_data.out_fade     <= fade_new;
      out_data.end_of_run   <= cmd.end_run;
    end
  end

  assign res_valid = out_valid;
  assign res_data  = out_data;

  always_comb begin
    stat.cur_silence = cur_silence;
    stat.cur_last    = cur_last;
    stat.held_valid  = held_valid;
    stat.out_free    = !out_valid || res_ready;
  end

endmodule

// File: sv/consonant_cluster_duration_scaler_unit.sv
`timescale 1ns / 1ps

// Consonant cluster duration scaler.
// Channel tok carries phoneme tokens in; channel res carries released tokens
// out; channel cfg writes the enable bit and the seven Q1.14 scales by index.
// cfg is always ready. A non-silence token is held until the next non-silence
// token or the end of its sequence, so its result comes one token late.
// Sequence: a token is taken in S_IDLE and planned in S_PLAN; it causes
// none, one or two results. Each passes S_SCALE, for the affricate factor,
// and S_EMIT, for the duration product, both on the single shared 16x15
// multiplier; S_EMIT waits while the output register is full. tok is ready
// again only when that work is done.
// Results sit in an output register; the next input is taken while a result
// waits. If res stalls while a second result is ready, the block holds it
// until the register frees up.
// Reset clears the held token and the neighbor class, sets all scales to 1.0
// and turns the adjustment off, so tokens pass with durations unchanged.

module consonant_cluster_duration_scaler_unit (
  input  logic        clk,
  input  logic        rst,
  ccds_tok_if.sink    tok,
  ccds_res_if.source  res,
  ccds_cfg_if.sink    cfg
);

  ccds_pkg::cmd_t  cmd;
  ccds_pkg::stat_t stat;

  ccds_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (tok.valid),
    .tok_ready (tok.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ccds_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .tok_data  (tok.data),
    .cfg_valid (cfg.valid),
    .cfg_ready (cfg.ready),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_data  (res.data)
  );

endmodule

// File: tb/sv/tb_consonant_cluster_duration_scaler_unit.sv
`timescale 1ns / 1ps

module tb_consonant_cluster_duration_scaler_unit;
  import ccds_pkg::*;

  localparam int unsigned RANDOM_ITEMS    = 830;
  localparam int unsigned SETTLE_CYCLES   = 12;
  localparam int unsigned DRAIN_LIMIT     = 5000;
  localparam int unsigned HOLD_OFF_CYCLES = 150;
  localparam longint unsigned TIMEOUT_NS  = 2_000_000;

  // An index with no register behind it; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 4'd12;

  logic clk = 1'b0;
  logic rst;

  ccds_tok_if tok();
  ccds_res_if res();
  ccds_cfg_if cfg();

  consonant_cluster_duration_scaler_unit DUT (
    .clk(clk),
    .rst(rst),
    .tok(tok),
    .res(res),
    .cfg(cfg)
  );

  always #2 clk = ~clk;

  // Register shadow and token-holding state of the predictor.
  logic                adj_enable;
  logic [SCALE_W-1:0]  scale_q14 [8];
  token_t              held;
  logic                holding;
  logic [CLS_W-1:0]    held_prior_cls;

  res_t        pending_releases [$];
  int unsigned error_count = 0;
  int unsigned items_sent = 0;
  bit          sender_burst = 1'b0;
  bit          res_burst = 1'b0;
  int unsigned hold_off_left = 0;

  function automatic int unsigned clamp_scale(int unsigned a, logic [SCALE_W-1:0] b);
    return (a < 32'(b)) ? a : 32'(b);
  endfunction

  // Works out the released beat of token k from its neighbor classes.
  function automatic res_t release_token(token_t k, logic [CLS_W-1:0] prior_cls,
                                         bit has_next, token_t nxt);
    res_t r;
    bit pc, nc, in_cluster, wfinal, cs, cf;
    int unsigned s, d, f;
    d = 32'(k.dur);
    f = 32'(k.fade);
    s = 32'(ONE_Q14);
    if (adj_enable && k.cls[CLS_CONS]) begin
      pc = prior_cls[CLS_CONS];
      nc = has_next && nxt.cls[CLS_CONS];
      in_cluster = pc || nc;
      wfinal = !has_next || nxt.wstart;
      cs = k.cls[CLS_STOP];
      cf = k.cls[CLS_FRIC];
      if (pc && nc) begin
        s = clamp_scale(s, scale_q14[REG_TRIPLE_MIDDLE]);
      end else begin
        // Pair with the following consonant.
        if (nc) begin
          if (cf && nxt.cls[CLS_STOP]) s = clamp_scale(s, scale_q14[REG_FRIC_BEFORE_STOP]);
          else if (cs && nxt.cls[CLS_FRIC]) s = clamp_scale(s, scale_q14[REG_STOP_BEFORE_FRIC]);
          else if (cf && nxt.cls[CLS_FRIC]) s = clamp_scale(s, scale_q14[REG_FRIC_BEFORE_FRIC]);
          else if (cs && nxt.cls[CLS_STOP]) s = clamp_scale(s, scale_q14[REG_STOP_BEFORE_STOP]);
        end
        // Pair with the preceding consonant; a stop after a fricative keeps its length.
        if (pc && !(prior_cls[CLS_FRIC] && cs)) begin
          if (prior_cls[CLS_STOP] && cf) s = clamp_scale(s, scale_q14[REG_STOP_BEFORE_FRIC]);
          else if (prior_cls[CLS_FRIC] && cf) s = clamp_scale(s, scale_q14[REG_FRIC_BEFORE_FRIC]);
          else if (prior_cls[CLS_STOP] && cs) s = clamp_scale(s, scale_q14[REG_STOP_BEFORE_STOP]);
        end
      end
      if (in_cluster && k.affricate) s = (s * 32'(AFFRICATE_SCALE)) >> FRAC_BITS;
      if (!k.wstart && !wfinal && !in_cluster) s = clamp_scale(s, scale_q14[REG_WORD_MEDIAL]);
      if (wfinal && (cs || cf)) s = clamp_scale(s, scale_q14[REG_WORD_FINAL_OBSTR]);
      // Only a shortening scale touches the duration.
      if (s < 32'(ONE_Q14)) begin
        d = (d * s) >> FRAC_BITS;
        if (d < 32'(MIN_DURATION)) d = 32'(MIN_DURATION);
        if (f > d) f = d;
      end
    end
    r.out_index = k.index;
    r.out_duration = DUR_W'(d);
    r.out_fade = DUR_W'(f);
    r.end_of_run = 1'b0;
    return r;
  endfunction

  // Advances the predictor by one accepted token and queues the beats it releases.
  function automatic void track_token(tok_in_t t);
    token_t cur;
    int unsigned queued;
    queued = pending_releases.size();
    cur = '0;
    cur.index = t.token_index;
    cur.cls[CLS_CONS] = !t.is_vowel;
    if (t.is_stop || t.is_affricate) cur.cls[CLS_STOP] = 1'b1;
    else if (t.frication_amplitude >= FRIC_THRESHOLD) cur.cls[CLS_FRIC] = 1'b1;
    cur.affricate = t.is_affricate;
    cur.wstart = t.word_start;
    cur.dur = t.duration;
    cur.fade = t.fade;
    if (!t.is_silence) begin
      if (holding) begin
        pending_releases.push_back(release_token(held, held_prior_cls, 1'b1, cur));
        held_prior_cls = held.cls;
      end
      held = cur;
      holding = 1'b1;
    end
    if (t.last_token) begin
      if (holding) pending_releases.push_back(release_token(held, held_prior_cls, 1'b0, held));
      holding = 1'b0;
      held_prior_cls = '0;
    end
    if (pending_releases.size() > queued)
      pending_releases[pending_releases.size() - 1].end_of_run = 1'b1;
  endfunction

  // Sends one token beat after a random gap, or none in burst mode, and waits for it to be taken.
  task automatic send_token(tok_in_t t);
    int unsigned gap;
    gap = sender_burst ? 0 : $urandom_range(0, 4);
    repeat (gap) begin
      @(negedge clk);
      tok.valid <= 1'b0;
    end
    @(negedge clk);
    tok.valid <= 1'b1;
    tok.data <= t;
    do @(posedge clk); while (!tok.ready);
    track_token(t);
    items_sent++;
  endtask

  // Writes one configuration register and updates the shadow copy.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= value;
    do @(posedge clk); while (!cfg.ready);
    case (idx)
      REG_ENABLE: adj_enable = value[0];
      REG_TRIPLE_MIDDLE, REG_FRIC_BEFORE_STOP, REG_STOP_BEFORE_FRIC, REG_FRIC_BEFORE_FRIC,
      REG_STOP_BEFORE_STOP, REG_WORD_MEDIAL, REG_WORD_FINAL_OBSTR: scale_q14[idx[2:0]] = value;
      default: ;
    endcase
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  // Stops sending, waits for every queued release and lets the block go idle.
  task automatic settle();
    int unsigned waited;
    waited = 0;
    @(negedge clk);
    tok.valid <= 1'b0;
    while (pending_releases.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic tok_in_t phone(int unsigned idx, bit sil, bit vow, bit stp, bit aff,
                                    int unsigned amp, bit ws, int unsigned dur,
                                    int unsigned fade, bit fin);
    tok_in_t t;
    t.token_index = INDEX_W'(idx);
    t.is_silence = sil;
    t.is_vowel = vow;
    t.is_stop = stp;
    t.is_affricate = aff;
    t.frication_amplitude = AMP_W'(amp);
    t.word_start = ws;
    t.duration = DUR_W'(dur);
    t.fade = DUR_W'(fade);
    t.last_token = fin;
    return t;
  endfunction

  // Draws a token mostly shaped like real speech, with some silence and odd flags.
  function automatic tok_in_t random_phone(bit ws, bit fin);
    tok_in_t t;
    int unsigned dur;
    t = '0;
    t.token_index = INDEX_W'($urandom_range(0, 1023));
    t.word_start = ws;
    t.last_token = fin;
    case ($urandom_range(0, 15))
      0: begin
        t.is_silence = 1'b1;
        t.is_vowel = 1'($urandom);
        t.is_stop = 1'($urandom);
        t.is_affricate = 1'($urandom);
        t.frication_amplitude = AMP_W'($urandom);
      end
      1: begin
        t.is_vowel = 1'($urandom);
        t.is_stop = 1'($urandom);
        t.is_affricate = 1'($urandom);
        t.frication_amplitude = AMP_W'($urandom);
      end
      2, 3, 4, 5, 6: begin
        t.is_vowel = 1'b1;
        t.frication_amplitude = AMP_W'($urandom_range(0, FRIC_THRESHOLD - 1));
      end
      7, 8: begin
        t.is_stop = 1'b1;
        t.frication_amplitude = AMP_W'($urandom);
      end
      9: begin
        t.is_affricate = 1'b1;
        t.frication_amplitude = AMP_W'($urandom);
      end
      10, 11, 12: begin
        t.frication_amplitude = ($urandom_range(0, 3) == 0) ? FRIC_THRESHOLD :
                                AMP_W'($urandom_range(FRIC_THRESHOLD, 65535));
      end
      default: begin
        t.frication_amplitude = ($urandom_range(0, 3) == 0) ? AMP_W'(FRIC_THRESHOLD - 1) :
                                AMP_W'($urandom_range(0, FRIC_THRESHOLD - 1));
      end
    endcase
    case ($urandom_range(0, 15))
      0: dur = 0;
      1: dur = 65535;
      2, 3: dur = $urandom_range(0, 65535);
      default: dur = $urandom_range(32, 3200);
    endcase
    t.duration = DUR_W'(dur);
    case ($urandom_range(0, 3))
      0: t.fade = DUR_W'($urandom_range(0, 65535));
      1: t.fade = DUR_W'(dur);
      default: t.fade = DUR_W'($urandom_range(0, dur / 2 + 16));
    endcase
    return t;
  endfunction

  // A sequence of tokens; a broken one never sends its closing mark.
  task automatic send_phrase(int unsigned len, bit broken);
    for (int unsigned i = 0; i < len; i++)
      send_token(random_phone((i == 0) || ($urandom_range(0, 2) == 0),
                              (i == len - 1) && !broken));
  endtask

  // Out of reset the adjustment is off, so every token passes unchanged.
  task automatic test_passthrough_after_reset();
    send_phrase(12, 1'b0);
    send_phrase(8, 1'b0);
    settle();
  endtask

  // Each cluster rule, the sequence-end cases and the field extremes.
  task automatic test_directed_rules();
    tok_in_t seq [$];
    write_reg(REG_ENABLE, 15'd1);
    write_reg(REG_TRIPLE_MIDDLE, 15'd8192);
    write_reg(REG_FRIC_BEFORE_STOP, 15'd10000);
    write_reg(REG_STOP_BEFORE_FRIC, 15'd12000);
    write_reg(REG_FRIC_BEFORE_FRIC, 15'd9000);
    write_reg(REG_STOP_BEFORE_STOP, 15'd11000);
    write_reg(REG_WORD_MEDIAL, 15'd14000);
    write_reg(REG_WORD_FINAL_OBSTR, 15'd6000);
    // Fricative before stop, triple middle, fricative after stop.
    seq.push_back(phone(0, 0, 1, 0, 0, 0, 1, 1600, 100, 0));
    seq.push_back(phone(1, 0, 0, 0, 0, 3277, 0, 1200, 65535, 0));
    seq.push_back(phone(2, 0, 0, 1, 0, 0, 0, 1000, 200, 0));
    seq.push_back(phone(3, 0, 0, 0, 0, 65535, 0, 900, 50, 0));
    seq.push_back(phone(4, 0, 1, 0, 0, 0, 0, 1500, 300, 0));
    // Silence with every flag set is skipped over.
    seq.push_back(phone(5, 1, 1, 1, 1, 65535, 1, 65535, 65535, 0));
    // Stop pair at the duration extremes; the zero duration is floored.
    seq.push_back(phone(6, 0, 0, 1, 0, 0, 0, 65535, 65535, 0));
    seq.push_back(phone(7, 0, 0, 1, 0, 0, 0, 0, 0, 0));
    seq.push_back(phone(8, 0, 1, 0, 0, 0, 0, 1400, 100, 0));
    // Word-medial affricate between vowels.
    seq.push_back(phone(9, 0, 0, 0, 1, 0, 0, 800, 800, 0));
    seq.push_back(phone(10, 0, 1, 0, 0, 0, 0, 1300, 100, 0));
    // Sonorant just under the threshold, then a fricative pair.
    seq.push_back(phone(11, 0, 0, 0, 0, 3276, 0, 700, 10, 0));
    seq.push_back(phone(12, 0, 0, 0, 0, 40000, 1, 1100, 400, 0));
    seq.push_back(phone(13, 0, 0, 0, 0, 20000, 0, 1000, 900, 0));
    seq.push_back(phone(14, 0, 1, 0, 0, 0, 0, 1200, 50, 0));
    // Word-final fricative, then a stop that ends the sequence.
    seq.push_back(phone(15, 0, 0, 0, 0, 5000, 0, 2000, 2000, 0));
    seq.push_back(phone(16, 0, 1, 0, 0, 0, 1, 1600, 60, 0));
    seq.push_back(phone(17, 0, 0, 1, 0, 0, 0, 1000, 1000, 1));
    // Silent end with nothing held, then a lone final stop.
    seq.push_back(phone(18, 1, 0, 0, 0, 0, 0, 0, 0, 1));
    seq.push_back(phone(19, 0, 0, 1, 0, 0, 1, 900, 900, 1));
    // Silent end releasing a held vowel.
    seq.push_back(phone(20, 0, 1, 0, 0, 0, 1, 1500, 100, 0));
    seq.push_back(phone(21, 1, 0, 0, 0, 0, 0, 100, 100, 1));
    // Affricate in a stop-fricative cluster at the start of a sequence.
    seq.push_back(phone(22, 0, 0, 0, 1, 60000, 1, 1000, 700, 0));
    seq.push_back(phone(23, 0, 0, 0, 0, 30000, 0, 1200, 100, 0));
    seq.push_back(phone(1023, 0, 1, 0, 0, 0, 0, 1600, 100, 1));
    foreach (seq[i]) send_token(seq[i]);
    settle();
  endtask

  // All scales at zero, at the top of their range, and just under one.
  task automatic test_scale_extremes();
    logic [SCALE_W-1:0] levels [3];
    levels[0] = '0;
    levels[1] = '1;
    levels[2] = SCALE_W'(ONE_Q14 - 1);
    foreach (levels[i]) begin
      settle();
      for (int r = int'(REG_TRIPLE_MIDDLE); r <= int'(REG_WORD_FINAL_OBSTR); r++)
        write_reg(CFG_IDX_W'(r), levels[i]);
      send_phrase(14, 1'b0);
    end
    settle();
  endtask

  // The result side holds off while tokens keep coming, so the input stalls.
  task automatic test_output_hold_off();
    sender_burst = 1'b1;
    hold_off_left = HOLD_OFF_CYCLES;
    send_phrase(24, 1'b0);
    send_phrase(10, 1'b0);
    sender_burst = 1'b0;
    settle();
  endtask

  // Random configurations, each followed by a stretch of random sequences.
  task automatic test_random_traffic();
    int unsigned target;
    int unsigned phase_end;
    logic [CFG_DATA_W-1:0] en_word;
    logic [SCALE_W-1:0] level;
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      settle();
      en_word = CFG_DATA_W'($urandom_range(0, 32767));
      en_word[0] = ($urandom_range(0, 3) != 0);
      write_reg(REG_ENABLE, en_word);
      for (int r = int'(REG_TRIPLE_MIDDLE); r <= int'(REG_WORD_FINAL_OBSTR); r++) begin
        case ($urandom_range(0, 7))
          0: level = '0;
          1: level = '1;
          2: level = ONE_Q14;
          3: level = SCALE_W'(ONE_Q14 - 1);
          4: level = SCALE_W'($urandom_range(0, 32767));
          default: level = SCALE_W'($urandom_range(4096, 16383));
        endcase
        write_reg(CFG_IDX_W'(r), level);
      end
      if ($urandom_range(0, 3) == 0)
        write_reg(REG_SPARE, CFG_DATA_W'($urandom_range(0, 32767)));
      sender_burst = ($urandom_range(0, 3) == 0);
      res_burst = ($urandom_range(0, 3) == 0);
      phase_end = items_sent + $urandom_range(20, 80);
      while (items_sent < phase_end && items_sent < target)
        send_phrase($urandom_range(1, 10), $urandom_range(0, 9) == 0);
    end
    send_phrase(3, 1'b0);
    sender_burst = 1'b0;
    res_burst = 1'b0;
    settle();
  endtask

  // Result side: random stalls per beat, plus a long hold-off on request.
  initial begin : res_sink
    int unsigned stall;
    res.ready = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      if (hold_off_left > 0) begin
        res.ready <= 1'b0;
        while (hold_off_left > 0) begin
          @(negedge clk);
          hold_off_left--;
        end
      end
      stall = res_burst ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        res.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      res.ready <= 1'b1;
      do @(posedge clk); while (!res.valid);
      @(negedge clk);
    end
  end

  // Compares every accepted result beat with the oldest queued release.
  always @(posedge clk) begin : result_check
    res_t got;
    res_t want;
    if (rst === 1'b0 && res.valid && res.ready) begin
      got = res.data;
      if (pending_releases.size() == 0) begin
        error_count++;
        $display("%0t ns: unexpected result beat, expected none, got %p", $time, got);
      end else begin
        want = pending_releases.pop_front();
        if (got.out_index !== want.out_index) begin
          error_count++;
          $display("%0t ns: out_index expected %0d, got %0d",
                   $time, want.out_index, got.out_index);
        end
        if (got.out_duration !== want.out_duration) begin
          error_count++;
          $display("%0t ns: out_duration expected %0d, got %0d (index %0d)",
                   $time, want.out_duration, got.out_duration, want.out_index);
        end
        if (got.out_fade !== want.out_fade) begin
          error_count++;
          $display("%0t ns: out_fade expected %0d, got %0d (index %0d)",
                   $time, want.out_fade, got.out_fade, want.out_index);
        end
        if (got.end_of_run !== want.end_of_run) begin
          error_count++;
          $display("%0t ns: end_of_run expected %0b, got %0b (index %0d)",
                   $time, want.end_of_run, got.end_of_run, want.out_index);
        end
      end
    end
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : run
    tok.valid = 1'b0;
    tok.data = '0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    adj_enable = 1'b0;
    foreach (scale_q14[i]) scale_q14[i] = ONE_Q14;
    held = '0;
    holding = 1'b0;
    held_prior_cls = '0;
    rst = 1'b1;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    test_passthrough_after_reset();
    test_directed_rules();
    test_scale_extremes();
    test_output_hold_off();
    test_random_traffic();

    // Anything still queued never came out.
    if (pending_releases.size() != 0) begin
      error_count++;
      $display("%0t ns: %0d result beats expected, 0 received; oldest %p",
               $time, pending_releases.size(), pending_releases[0]);
    end
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/ccds_pkg.sv
sv/ccds_tok_if.sv
sv/ccds_res_if.sv
sv/ccds_cfg_if.sv
sv/ccds_ctrl.sv
sv/ccds_datapath.sv
sv/consonant_cluster_duration_scaler_unit.sv
tb/sv/tb_consonant_cluster_duration_scaler_unit.sv
